[src/rtc_bcd_to_epoch_and_weekday_unit_macros.svh]
// assertion macros shared by the rtc bcd to epoch unit
`ifndef RTC_BCD_TO_EPOCH_AND_WEEKDAY_UNIT_MACROS_SVH
`define RTC_BCD_TO_EPOCH_AND_WEEKDAY_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition implies consequence in the same cycle
`define RBE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbe assertion failed");
// condition implies consequence in the following cycle
`define RBE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rbe assertion failed");
`else
`define RBE_ASSERT_IMPL(lbl, ante, cons)
`define RBE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/rbe_pkg.sv]
// types, constants and table functions for the rtc bcd to epoch unit
package rbe_pkg;

	localparam int unsigned BIN_W      = 7;
	localparam int unsigned MON_W      = 4;
	localparam int unsigned DAYS_W     = 15;
	localparam int unsigned SECS_W     = 19;
	localparam int unsigned WSUM_W     = 8;
	localparam logic [6:0]  MIN_YEAR_RST = 7'd18;
	localparam logic [31:0] SECS_PER_DAY = 32'd86400;
	// 2000-01-01 minus one day, since the day count carries day rather than day - 1
	localparam logic [31:0] EPOCH_BASE   = 32'd946598400;

	typedef struct packed {
		logic [7:0] seconds_bcd;
		logic [7:0] minutes_bcd;
		logic [7:0] hours_bcd;
		logic [7:0] day_bcd;
		logic [7:0] month_bcd;
		logic [7:0] year_bcd;
	} in_t;

	typedef struct packed {
		logic [6:0]  seconds_bin;
		logic [6:0]  minutes_bin;
		logic [6:0]  hours_bin;
		logic [6:0]  day_bin;
		logic [6:0]  month_bin;
		logic [6:0]  year_bin;
		logic [2:0]  week_day;
		logic [31:0] epoch_seconds;
		logic        year_too_early;
	} out_t;

	typedef struct packed {
		logic [BIN_W-1:0] sec;
		logic [BIN_W-1:0] min;
		logic [BIN_W-1:0] hour;
		logic [BIN_W-1:0] day;
		logic [BIN_W-1:0] mon;
		logic [BIN_W-1:0] year;
		logic [MON_W-1:0] mon_cl;
		logic             too_early;
	} dec_t;

	typedef struct packed {
		logic [BIN_W-1:0]  sec;
		logic [BIN_W-1:0]  min;
		logic [BIN_W-1:0]  hour;
		logic [BIN_W-1:0]  day;
		logic [BIN_W-1:0]  mon;
		logic [BIN_W-1:0]  year;
		logic              too_early;
		logic [DAYS_W-1:0] days;
		logic [SECS_W-1:0] secs;
		logic [WSUM_W-1:0] wsum;
	} sum_t;

	function automatic logic [BIN_W-1:0] bcd_decode(input logic [7:0] b);
		return BIN_W'(b[3:0]) + BIN_W'(b[6:4]) * BIN_W'(10);
	endfunction

	// days before the first of the month, common year
	function automatic logic [8:0] days_before(input logic [MON_W-1:0] m);
		logic [8:0] d;
		unique case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	// (31 * shifted month / 12 + 1) mod 7, year and century terms folded elsewhere
	function automatic logic [2:0] week_offset(input logic [MON_W-1:0] m);
		logic [2:0] w;
		unique case (m)
			4'd1:    w = 3'd1;
			4'd2:    w = 3'd4;
			4'd3:    w = 3'd3;
			4'd4:    w = 3'd6;
			4'd5:    w = 3'd1;
			4'd6:    w = 3'd4;
			4'd7:    w = 3'd6;
			4'd8:    w = 3'd2;
			4'd9:    w = 3'd5;
			4'd10:   w = 3'd0;
			4'd11:   w = 3'd3;
			4'd12:   w = 3'd5;
			default: w = 3'd0;
		endcase
		return w;
	endfunction

	// mod 7 by folding: 64 and 8 are both 1 mod 7
	function automatic logic [2:0] mod7(input logic [WSUM_W-1:0] x);
		logic [6:0] a;
		logic [3:0] b;
		logic [2:0] r;
		a = 7'(x[7:6]) + 7'(x[5:0]);
		b = 4'(a[6:3]) + 4'(a[2:0]);
		priority if (b >= 4'd14) r = 3'(b - 4'd14);
		else if (b >= 4'd7)      r = 3'(b - 4'd7);
		else                     r = b[2:0];
		return r;
	endfunction

endpackage

[src/rbe_decode.sv]
// stage 1: bcd decode, month clamp and minimum year compare
module rbe_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	input  rbe_pkg::in_t     up_data,
	input  logic [6:0]       min_year,
	input  logic             down_ready,
	output logic             ready,
	output logic             valid_s1,
	output rbe_pkg::dec_t    data_s1
);

	rbe_pkg::dec_t nxt;
	logic [rbe_pkg::BIN_W-1:0] mon;

	assign ready = !valid_s1 || down_ready;

	always_comb begin
		nxt.sec       = rbe_pkg::bcd_decode(up_data.seconds_bcd);
		nxt.min       = rbe_pkg::bcd_decode(up_data.minutes_bcd);
		nxt.hour      = rbe_pkg::bcd_decode(up_data.hours_bcd);
		nxt.day       = rbe_pkg::bcd_decode(up_data.day_bcd);
		mon           = rbe_pkg::bcd_decode(up_data.month_bcd);
		nxt.mon       = mon;
		nxt.year      = rbe_pkg::bcd_decode(up_data.year_bcd);
		priority if (mon == '0)       nxt.mon_cl = 4'd1;
		else if (mon > 7'd12)         nxt.mon_cl = 4'd12;
		else                          nxt.mon_cl = mon[3:0];
		nxt.too_early = nxt.year < min_year;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && up_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

[src/rbe_sum.sv]
// stage 2: day count, second of day and weekday sum
module rbe_sum (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	input  rbe_pkg::dec_t    up_data,
	input  logic             down_ready,
	output logic             ready,
	output logic             valid_s2,
	output rbe_pkg::sum_t    data_s2
);

	rbe_pkg::sum_t nxt;
	logic [7:0] leaps;
	logic [6:0] y_off;
	logic       early_mon;
	logic       leap_adj;

	assign ready = !valid_s2 || down_ready;

	always_comb begin
		nxt.sec       = up_data.sec;
		nxt.min       = up_data.min;
		nxt.hour      = up_data.hour;
		nxt.day       = up_data.day;
		nxt.mon       = up_data.mon;
		nxt.year      = up_data.year;
		nxt.too_early = up_data.too_early;
		early_mon     = up_data.mon_cl <= 4'd2;
		// leap days in 2000 .. year-1, zero for year 2000 itself
		leaps         = (8'(up_data.year) + 8'd3) >> 2;
		leap_adj      = (up_data.year[1:0] == 2'b00) && !early_mon;
		nxt.days      = rbe_pkg::DAYS_W'(up_data.year) * rbe_pkg::DAYS_W'(365)
		              + rbe_pkg::DAYS_W'(leaps)
		              + rbe_pkg::DAYS_W'(rbe_pkg::days_before(up_data.mon_cl))
		              + rbe_pkg::DAYS_W'(up_data.day)
		              + rbe_pkg::DAYS_W'(leap_adj);
		nxt.secs      = rbe_pkg::SECS_W'(up_data.hour) * rbe_pkg::SECS_W'(3600)
		              + rbe_pkg::SECS_W'(up_data.min) * rbe_pkg::SECS_W'(60)
		              + rbe_pkg::SECS_W'(up_data.sec);
		// year offset by four so the jan/feb borrow stays positive
		y_off         = up_data.year + 7'd4 - 7'(early_mon);
		nxt.wsum      = rbe_pkg::WSUM_W'(up_data.day) + rbe_pkg::WSUM_W'(y_off)
		              + rbe_pkg::WSUM_W'(y_off[6:2])
		              + rbe_pkg::WSUM_W'(rbe_pkg::week_offset(up_data.mon_cl));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && up_valid) begin
			data_s2 <= nxt;
		end
	end

endmodule

[src/rbe_final.sv]
// stage 3: epoch scaling, weekday reduction and output register
module rbe_final (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	input  rbe_pkg::sum_t    up_data,
	input  logic             down_ready,
	output logic             ready,
	output logic             valid_s3,
	output rbe_pkg::out_t    data_s3
);

	rbe_pkg::out_t nxt;

	assign ready = !valid_s3 || down_ready;

	always_comb begin
		nxt.seconds_bin    = up_data.sec;
		nxt.minutes_bin    = up_data.min;
		nxt.hours_bin      = up_data.hour;
		nxt.day_bin        = up_data.day;
		nxt.month_bin      = up_data.mon;
		nxt.year_bin       = up_data.year;
		nxt.year_too_early = up_data.too_early;
		nxt.week_day       = rbe_pkg::mod7(up_data.wsum);
		// wraps modulo 2^32
		nxt.epoch_seconds  = rbe_pkg::EPOCH_BASE
		                   + 32'(up_data.days) * rbe_pkg::SECS_PER_DAY
		                   + 32'(up_data.secs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && up_valid) begin
			data_s3 <= nxt;
		end
	end

endmodule

[src/rtc_bcd_to_epoch_and_weekday_unit.sv]
// top level of the rtc bcd snapshot to epoch seconds and weekday unit
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------
//   in      | in_valid / in_stall  | in_data   (six bcd bytes)
//   out     | out_valid / out_stall| out_data  (binary, weekday, epoch)
//   cfg     | cfg_valid / cfg_ready| cfg_data  (min_valid_year)
//
// three register stages: decode, sums, epoch multiply and output register
// one item per cycle sustained while out_stall stays low
// each stage holds its item while the next one is full and cannot pass its own item on, bubbles are squeezed out
// reset empties the pipeline and sets min_valid_year to 18
// cfg_ready is always high
`include "rtc_bcd_to_epoch_and_weekday_unit_macros.svh"

module rtc_bcd_to_epoch_and_weekday_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  rbe_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output rbe_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [6:0]    cfg_data
);

	logic          cfg_write;
	logic [6:0]    min_year_q;
	logic          ready_s1;
	logic          ready_s2;
	logic          ready_s3;
	logic          valid_s1;
	logic          valid_s2;
	rbe_pkg::dec_t data_s1;
	rbe_pkg::sum_t data_s2;

	assign cfg_ready = 1'b1;
	assign in_stall  = !ready_s1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= rbe_pkg::MIN_YEAR_RST;
		end else if (cfg_write) begin
			min_year_q <= cfg_data;
		end
	end

	rbe_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (in_valid),
		.up_data    (in_data),
		.min_year   (min_year_q),
		.down_ready (ready_s2),
		.ready      (ready_s1),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1)
	);

	rbe_sum u_sum (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (valid_s1),
		.up_data    (data_s1),
		.down_ready (ready_s3),
		.ready      (ready_s2),
		.valid_s2   (valid_s2),
		.data_s2    (data_s2)
	);

	rbe_final u_final (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (valid_s2),
		.up_data    (data_s2),
		.down_ready (!out_stall),
		.ready      (ready_s3),
		.valid_s3   (out_valid),
		.data_s3    (out_data)
	);

	// weekday reduction never leaves 0..6
	`RBE_ASSERT_IMPL(a_weekday_range, out_valid, out_data.week_day != 3'd7)
	// input is held off only when the first stage is occupied
	`RBE_ASSERT_IMPL(a_stall_full, in_stall, valid_s1)
	// a blocked first stage keeps its item
	`RBE_ASSERT_NEXT(a_s1_hold, valid_s1 && !ready_s2, valid_s1 && $stable(data_s1))
	// register write lands
	`RBE_ASSERT_NEXT(a_cfg_write, cfg_write, min_year_q == $past(cfg_data))

endmodule

[verif/tb_rtc_bcd_to_epoch_and_weekday_unit.sv]
// testbench for the rtc bcd snapshot to epoch seconds and weekday unit
`timescale 1ns / 1ps

module tb_rtc_bcd_to_epoch_and_weekday_unit;

	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned SHOW_LIMIT     = 20;
	localparam bit [31:0]   UNIX_2000      = 32'd946684800;
	localparam bit [31:0]   DAY_SECS       = 32'd86400;
	localparam bit [31:0]   YEAR_SECS      = 32'd31536000;
	localparam bit [31:0]   HOUR_SECS      = 32'd3600;
	localparam bit [31:0]   MIN_SECS       = 32'd60;
	localparam int unsigned MONTH_START [12] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	// holds the stamps still owed by the block and computes new ones
	class stamp_board;
		rbe_pkg::out_t expected_stamps[$];
		logic [6:0]    min_year;
		int unsigned   errors;
		int unsigned   checked;

		function new();
			min_year = 7'd18;
			errors   = 0;
			checked  = 0;
		endfunction

		function int unsigned pending();
			return expected_stamps.size();
		endfunction

		function int unsigned bcd_value(logic [7:0] b);
			return int'(b[3:0]) + 10 * int'(b[6:4]);
		endfunction

		function rbe_pkg::out_t stamp_of(rbe_pkg::in_t s);
			rbe_pkg::out_t r;
			int unsigned   sec, mnt, hr, dy, mon, yr, mc, a, y, m, sum;
			bit [31:0]     t, leaps;
			sec = bcd_value(s.seconds_bcd);
			mnt = bcd_value(s.minutes_bcd);
			hr  = bcd_value(s.hours_bcd);
			dy  = bcd_value(s.day_bcd);
			mon = bcd_value(s.month_bcd);
			yr  = bcd_value(s.year_bcd);
			mc  = (mon < 1) ? 1 : ((mon > 12) ? 12 : mon);
			// january and february count as months 11 and 12 of the year before
			a   = (mc <= 2) ? 1 : 0;
			y   = 2000 + yr - a;
			m   = mc + 12 * a - 2;
			sum = dy + y + y / 4 - y / 100 + y / 400 + (31 * m) / 12;
			// leap days of the years before this one, year zero has none before it
			leaps = (yr == 0) ? 0 : (yr - 1) / 4 + 1;
			t = UNIX_2000 + yr * YEAR_SECS + leaps * DAY_SECS
				+ MONTH_START[mc - 1] * DAY_SECS + (dy - 1) * DAY_SECS
				+ hr * HOUR_SECS + mnt * MIN_SECS + sec;
			if (yr % 4 == 0 && mc > 2)
				t = t + DAY_SECS;
			r.seconds_bin    = 7'(sec);
			r.minutes_bin    = 7'(mnt);
			r.hours_bin      = 7'(hr);
			r.day_bin        = 7'(dy);
			r.month_bin      = 7'(mon);
			r.year_bin       = 7'(yr);
			r.week_day       = 3'((sum + 6) % 7);
			r.epoch_seconds  = t;
			r.year_too_early = (yr < min_year);
			return r;
		endfunction

		function void note_snapshot(rbe_pkg::in_t s);
			expected_stamps.push_back(stamp_of(s));
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			if (errors <= SHOW_LIMIT)
				$display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $time);
		endtask

		task check_stamp(rbe_pkg::out_t got);
			rbe_pkg::out_t want;
			if (expected_stamps.size() == 0) begin
				report("item with none pending", got.epoch_seconds, 0);
				return;
			end
			want = expected_stamps.pop_front();
			checked++;
			if (got.seconds_bin !== want.seconds_bin)
				report("seconds_bin", got.seconds_bin, want.seconds_bin);
			if (got.minutes_bin !== want.minutes_bin)
				report("minutes_bin", got.minutes_bin, want.minutes_bin);
			if (got.hours_bin !== want.hours_bin)
				report("hours_bin", got.hours_bin, want.hours_bin);
			if (got.day_bin !== want.day_bin)
				report("day_bin", got.day_bin, want.day_bin);
			if (got.month_bin !== want.month_bin)
				report("month_bin", got.month_bin, want.month_bin);
			if (got.year_bin !== want.year_bin)
				report("year_bin", got.year_bin, want.year_bin);
			if (got.week_day !== want.week_day)
				report("week_day", got.week_day, want.week_day);
			if (got.epoch_seconds !== want.epoch_seconds)
				report("epoch_seconds", got.epoch_seconds, want.epoch_seconds);
			if (got.year_too_early !== want.year_too_early)
				report("year_too_early", got.year_too_early, want.year_too_early);
		endtask
	endclass

	logic          clk = 1'b0;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	rbe_pkg::in_t  in_data;
	logic          out_valid;
	logic          out_stall;
	rbe_pkg::out_t out_data;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [6:0]    cfg_data;

	stamp_board    board;
	rbe_pkg::in_t  corners[$];
	int unsigned   send_pct = 0;
	int unsigned   stall_pct = 0;
	int unsigned   sent = 0;
	int unsigned   settings = 0;
	int unsigned   quiet_cycles = 0;

	rtc_bcd_to_epoch_and_weekday_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			board.note_snapshot(in_data);
		if (arst_n && out_valid && !out_stall)
			board.check_stamp(out_data);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// receiver stalls in bursts
	initial begin
		int unsigned span;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) < stall_pct) begin
				span = $urandom_range(1, 18);
				out_stall <= 1'b1;
				repeat (span) @(posedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	function automatic int unsigned pick_pct();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 6;
			default: return 25;
		endcase
	endfunction

	function automatic rbe_pkg::in_t snap(logic [7:0] sec, logic [7:0] mnt, logic [7:0] hr,
		logic [7:0] dy, logic [7:0] mon, logic [7:0] yr);
		return {sec, mnt, hr, dy, mon, yr};
	endfunction

	// proper bcd digits, bit 7 left random
	function automatic logic [7:0] as_bcd(int unsigned v);
		return {1'($urandom_range(0, 1)), 3'(v / 10), 4'(v % 10)};
	endfunction

	function automatic rbe_pkg::in_t random_snapshot();
		rbe_pkg::in_t s;
		if ($urandom_range(0, 3) == 0) begin
			s = {$urandom, 16'($urandom)};
		end else begin
			s.seconds_bcd = as_bcd($urandom_range(0, 59));
			s.minutes_bcd = as_bcd($urandom_range(0, 59));
			s.hours_bcd   = as_bcd($urandom_range(0, 23));
			s.day_bcd     = as_bcd($urandom_range(1, 31));
			s.month_bcd   = as_bcd($urandom_range(1, 12));
			s.year_bcd    = as_bcd($urandom_range(0, 79));
		end
		return s;
	endfunction

	task automatic send_snapshot(input rbe_pkg::in_t s);
		int unsigned gap;
		if ($urandom_range(0, 99) < send_pct) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	// drain the pipeline, then change the minimum year
	task automatic settle_and_set(input logic [6:0] floor_year);
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= floor_year;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.min_year = floor_year;
		settings++;
	endtask

	initial begin
		logic [6:0] year_floors [6];
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		board = new();
		year_floors = '{7'd0, 7'd127, 7'd99, 7'd1, 7'($urandom_range(0, 127)), 7'd18};
		corners = '{
			snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00),  // first second of 2000
			snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h79),
			snap(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00),  // leap day of year zero
			snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00),
			snap(8'h59, 8'h59, 8'h23, 8'h28, 8'h02, 8'h01),
			snap(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h24),
			snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h24),
			snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),  // day and month zero
			snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
			snap(8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F),
			snap(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80),  // only bit 7 set
			snap(8'h00, 8'h00, 8'h12, 8'h15, 8'h13, 8'h24),  // month past december
			snap(8'h30, 8'h30, 8'h12, 8'h15, 8'h1F, 8'h50),
			snap(8'h3A, 8'h4B, 8'h2C, 8'h3D, 8'h0E, 8'h5F),  // digits above nine
			snap(8'h00, 8'h00, 8'h12, 8'h15, 8'h06, 8'h17),  // just below the floor
			snap(8'h00, 8'h00, 8'h12, 8'h15, 8'h06, 8'h18),
			snap(8'h07, 8'h14, 8'h03, 8'h19, 8'h01, 8'h38),
			snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h10, 8'h10),
			snap(8'h00, 8'h00, 8'h00, 8'h31, 8'h01, 8'h00),
			snap(8'h0F, 8'hF0, 8'h8F, 8'h55, 8'h92, 8'hC5),
			snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01),
			snap(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01),
			snap(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h00)
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		send_pct  = pick_pct();
		stall_pct = pick_pct();
		foreach (corners[i])
			send_snapshot(corners[i]);
		repeat (20)
			send_snapshot(random_snapshot());
		foreach (year_floors[p]) begin
			settle_and_set(year_floors[p]);
			// last stretch runs at full rate
			if (p == 5) begin
				send_pct  = 0;
				stall_pct = 0;
			end else begin
				send_pct  = pick_pct();
				stall_pct = pick_pct();
			end
			repeat (130)
				send_snapshot(random_snapshot());
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		$display("%0d snapshots sent, %0d of them hand-picked corners, %0d results compared",
			sent, corners.size(), board.checked);
		$display("minimum year rewritten %0d times, including 0, 127 and the reset value",
			settings);
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/rbe_pkg.sv
src/rbe_decode.sv
src/rbe_sum.sv
src/rbe_final.sv
src/rtc_bcd_to_epoch_and_weekday_unit.sv
verif/tb_rtc_bcd_to_epoch_and_weekday_unit.sv
